### src/assert_macros.svh
// Assertion macros used by the checker module of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/stt_pkg.sv
// Package with token codes, token layout and sizes for the source text tokenizer.
`default_nettype none

package stt_pkg;

   // Token kinds.
   localparam logic [3:0] KIND_ARITH    = 4'd0;
   localparam logic [3:0] KIND_SEMI     = 4'd1;
   localparam logic [3:0] KIND_COMMA    = 4'd2;
   localparam logic [3:0] KIND_COLON    = 4'd3;
   localparam logic [3:0] KIND_EOF      = 4'd4;
   localparam logic [3:0] KIND_RELATION = 4'd5;
   localparam logic [3:0] KIND_ASSIGN   = 4'd6;
   localparam logic [3:0] KIND_ERROR    = 4'd7;
   localparam logic [3:0] KIND_PAREN    = 4'd8;
   localparam logic [3:0] KIND_BRACE    = 4'd9;
   localparam logic [3:0] KIND_NUMBER   = 4'd10;
   localparam logic [3:0] KIND_IDENT    = 4'd11;
   localparam logic [3:0] KIND_VAR      = 4'd12;
   localparam logic [3:0] KIND_PRINT    = 4'd13;
   localparam logic [3:0] KIND_IF       = 4'd14;
   localparam logic [3:0] KIND_WHILE    = 4'd15;

   // Symbol codes.
   localparam logic [3:0] SYM_NONE   = 4'd0;
   localparam logic [3:0] SYM_PLUS   = 4'd1;
   localparam logic [3:0] SYM_MINUS  = 4'd2;
   localparam logic [3:0] SYM_STAR   = 4'd3;
   localparam logic [3:0] SYM_SLASH  = 4'd4;
   localparam logic [3:0] SYM_EQ     = 4'd5;
   localparam logic [3:0] SYM_NE     = 4'd6;
   localparam logic [3:0] SYM_LE     = 4'd7;
   localparam logic [3:0] SYM_LT     = 4'd8;
   localparam logic [3:0] SYM_GE     = 4'd9;
   localparam logic [3:0] SYM_GT     = 4'd10;
   localparam logic [3:0] SYM_LPAREN = 4'd11;
   localparam logic [3:0] SYM_RPAREN = 4'd12;
   localparam logic [3:0] SYM_LBRACE = 4'd13;
   localparam logic [3:0] SYM_RBRACE = 4'd14;

   // Identifier limits.
   localparam int NAME_SLOTS = 31;
   localparam int MAX_NAME   = 31;

   localparam logic [30:0] NUM_MAX        = 31'h7FFF_FFFF;
   localparam logic [7:0]  FIRST_LINE_RST = 8'hFD;   // -3

   localparam int FIFO_DEPTH  = 4;
   localparam int RSP_TDATA_W = 312;

   // One token, first field in the highest bits.
   typedef struct packed {
      logic signed [15:0]        line_num;
      logic [NAME_SLOTS*8-1:0]   chars;
      logic [4:0]                length;
      logic [30:0]               value;
      logic [3:0]                symbol;
      logic [3:0]                kind;
   } token_type;

   localparam int TOKEN_W = $bits(token_type);

   typedef struct packed {
      logic      last;
      token_type tok;
   } entry_type;

   function automatic token_type make_token(logic [3:0] kind, logic [3:0] symbol,
                                            logic signed [15:0] line_num);
      token_type t;
      t          = '0;
      t.kind     = kind;
      t.symbol   = symbol;
      t.line_num = line_num;
      return t;
   endfunction

endpackage

`default_nettype wire

### src/source_text_tokenizer_core.sv
// A taken character's tokens are registered into the result queue; rsp shows its head.
// Throughput: one character per cycle while the four-entry result queue holds two tokens or
// fewer; rsp drains one token per cycle while rsp_tready is high, so characters that keep
// yielding two tokens fill the queue and req_tready drops until it is back down to two.
// Reset (synchronous, active high) empties the result queue, clears the lexer state,
// returns to the start-of-text mode and sets first_line_number to -3.
`default_nettype none

module source_text_tokenizer_core (
   input  wire logic         clock,
   input  wire logic         reset,
   // Character channel. tdata: char_code[7:0]. tlast: end_of_text.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         req_tlast,
   // Token channel. tdata from bit 0 up: token_kind[3:0], symbol_code[3:0],
   // number_value[30:0], name_length[4:0], name_chars_a[63:0], name_chars_b[63:0],
   // name_chars_c[63:0], name_chars_d[55:0], line_number[15:0], zero pad[3:0].
   // tlast: last_of_run.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [stt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   // Configuration channel. data: first_line_number[7:0], signed.
   // The channel is always ready; a write takes effect at the next start of text.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   // Lexer modes. Fresh means the next character starts a new text.
   localparam logic [2:0] M_FRESH = 3'd0;
   localparam logic [2:0] M_IDLE  = 3'd1;
   localparam logic [2:0] M_NUM   = 3'd2;
   localparam logic [2:0] M_IDENT = 3'd3;
   localparam logic [2:0] M_EQ    = 3'd4;
   localparam logic [2:0] M_BANG  = 3'd5;
   localparam logic [2:0] M_LT    = 3'd6;
   localparam logic [2:0] M_GT    = 3'd7;

   localparam int PTR_W = $clog2(stt_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(stt_pkg::FIFO_DEPTH + 1);

   // Configuration register.
   logic [7:0]          first_line_ff;

   // Lexer state.
   logic [2:0]          mode_ff, mode_in;
   logic [4:0]          fill_ff, fill_in;
   logic [30:0]         accum_ff, accum_in;
   logic signed [15:0]  line_ff, line_in;
   logic [7:0]          name_ff [stt_pkg::NAME_SLOTS];

   // Name store write port.
   logic                name_we;
   logic [4:0]          name_waddr;
   logic [7:0]          name_wdata;

   // Result queue.
   stt_pkg::entry_type  fifo_ff [stt_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   logic                item_xfer;
   logic                rsp_xfer;
   logic [7:0]          ch;
   logic                is_digit;
   logic                is_alpha;
   logic [2:0]          mode_eff;
   logic signed [15:0]  line_base;
   logic [34:0]         num_next;
   logic [stt_pkg::NAME_SLOTS*8-1:0] ident_chars;

   // Pending token that a flush emits, and the tokens produced for this character.
   logic                flush_valid;
   stt_pkg::token_type  flush_tok;
   logic                a_valid, b_valid;
   stt_pkg::token_type  a_tok, b_tok;
   logic [PTR_W-1:0]    b_idx;
   logic [CNT_W-1:0]    push_n;

   assign csr_ready  = 1'b1;

   // Room for two tokens is kept before a character is taken, so a character
   // never has to be refused halfway.
   assign req_tready = (count_ff <= CNT_W'(stt_pkg::FIFO_DEPTH - 2));
   assign item_xfer  = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = stt_pkg::RSP_TDATA_W'(fifo_ff[rd_ptr_ff].tok);
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

   assign ch       = req_tdata;
   assign is_digit = (ch >= "0") && (ch <= "9");
   assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));

   // At the start of a text the line count is loaded from the register before
   // anything else, and the mode behaves as idle.
   assign mode_eff  = (mode_ff == M_FRESH) ? M_IDLE : mode_ff;
   assign line_base = (mode_ff == M_FRESH) ? {{8{first_line_ff[7]}}, first_line_ff} : line_ff;

   // Decimal accumulate: value * 10 + digit, by shift and add.
   assign num_next = 35'({accum_ff, 3'b000}) + 35'({accum_ff, 1'b0}) + 35'(ch - "0");

   // Identifier bytes at and beyond the fill are shown as zero.
   always_comb begin
      for (int i = 0; i < stt_pkg::NAME_SLOTS; i++) begin
         ident_chars[i*8 +: 8] = (5'(i) < fill_ff) ? name_ff[i] : 8'h00;
      end
   end

   // Token held by the current mode, emitted when the mode is left.
   always_comb begin
      flush_valid = 1'b1;
      flush_tok   = stt_pkg::make_token(stt_pkg::KIND_ERROR, stt_pkg::SYM_NONE, line_base);
      case (mode_eff)
         M_NUM: begin
            flush_tok.kind  = stt_pkg::KIND_NUMBER;
            flush_tok.value = accum_ff;
         end
         M_IDENT: begin
            if (fill_ff == 5'd3 && name_ff[0] == "v" && name_ff[1] == "a"
                && name_ff[2] == "r") begin
               flush_tok.kind = stt_pkg::KIND_VAR;
            end else if (fill_ff == 5'd5 && name_ff[0] == "p" && name_ff[1] == "r"
                         && name_ff[2] == "i" && name_ff[3] == "n"
                         && name_ff[4] == "t") begin
               flush_tok.kind = stt_pkg::KIND_PRINT;
            end else if (fill_ff == 5'd2 && name_ff[0] == "i" && name_ff[1] == "f") begin
               flush_tok.kind = stt_pkg::KIND_IF;
            end else if (fill_ff == 5'd5 && name_ff[0] == "w" && name_ff[1] == "h"
                         && name_ff[2] == "i" && name_ff[3] == "l"
                         && name_ff[4] == "e") begin
               flush_tok.kind = stt_pkg::KIND_WHILE;
            end else begin
               flush_tok.kind   = stt_pkg::KIND_IDENT;
               flush_tok.length = fill_ff;
               flush_tok.chars  = ident_chars;
            end
         end
         M_EQ:   flush_tok.kind = stt_pkg::KIND_ASSIGN;
         M_BANG: flush_tok.kind = stt_pkg::KIND_ERROR;   // a lone ! is an error
         M_LT: begin
            flush_tok.kind   = stt_pkg::KIND_RELATION;
            flush_tok.symbol = stt_pkg::SYM_LT;
         end
         M_GT: begin
            flush_tok.kind   = stt_pkg::KIND_RELATION;
            flush_tok.symbol = stt_pkg::SYM_GT;
         end
         default: flush_valid = 1'b0;
      endcase
   end

   // Next state and tokens of one character. Token a is always the flushed
   // token, token b the one the character itself makes; either may be absent.
   always_comb begin
      mode_in    = mode_eff;
      fill_in    = fill_ff;
      accum_in   = accum_ff;
      line_in    = line_base;
      name_we    = 1'b0;
      name_waddr = fill_ff;
      name_wdata = ch;
      a_valid    = 1'b0;
      a_tok      = flush_tok;
      b_valid    = 1'b0;
      b_tok      = stt_pkg::make_token(stt_pkg::KIND_ERROR, stt_pkg::SYM_NONE, line_base);

      if (req_tlast) begin
         // End of text: pending token, then eof, then back to the fresh mode.
         a_valid    = flush_valid;
         b_valid    = 1'b1;
         b_tok.kind = stt_pkg::KIND_EOF;
         mode_in    = M_FRESH;
         fill_in    = '0;
         accum_in   = '0;
      end else if (mode_eff == M_NUM && is_digit) begin
         accum_in = (num_next > 35'(stt_pkg::NUM_MAX)) ? stt_pkg::NUM_MAX : num_next[30:0];
      end else if (mode_eff == M_IDENT && (is_alpha || is_digit)
                   && fill_ff < 5'(stt_pkg::MAX_NAME)) begin
         name_we = 1'b1;
         fill_in = fill_ff + 5'd1;
      end else if (mode_eff >= M_EQ && ch == "=") begin
         // Two-character relation closes the pending =, !, < or >.
         b_valid    = 1'b1;
         b_tok.kind = stt_pkg::KIND_RELATION;
         case (mode_eff)
            M_EQ:    b_tok.symbol = stt_pkg::SYM_EQ;
            M_BANG:  b_tok.symbol = stt_pkg::SYM_NE;
            M_LT:    b_tok.symbol = stt_pkg::SYM_LE;
            default: b_tok.symbol = stt_pkg::SYM_GE;
         endcase
         mode_in = M_IDLE;
      end else begin
         // The character cannot extend the pending token: flush it, then
         // treat the character as the start of something new.
         a_valid  = flush_valid;
         mode_in  = M_IDLE;
         fill_in  = '0;
         accum_in = '0;
         case (ch)
            " ", "\t", "\r": ;
            "\n": begin
               if (line_base != 16'sh7FFF) begin
                  line_in = line_base + 16'sd1;
               end
            end
            "+": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_ARITH; b_tok.symbol = stt_pkg::SYM_PLUS;
            end
            "-": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_ARITH; b_tok.symbol = stt_pkg::SYM_MINUS;
            end
            "*": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_ARITH; b_tok.symbol = stt_pkg::SYM_STAR;
            end
            "/": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_ARITH; b_tok.symbol = stt_pkg::SYM_SLASH;
            end
            ";": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_SEMI;
            end
            ",": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_COMMA;
            end
            ":": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_COLON;
            end
            "(": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_PAREN; b_tok.symbol = stt_pkg::SYM_LPAREN;
            end
            ")": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_PAREN; b_tok.symbol = stt_pkg::SYM_RPAREN;
            end
            "{": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_BRACE; b_tok.symbol = stt_pkg::SYM_LBRACE;
            end
            "}": begin
               b_valid = 1'b1; b_tok.kind = stt_pkg::KIND_BRACE; b_tok.symbol = stt_pkg::SYM_RBRACE;
            end
            "=": mode_in = M_EQ;
            "!": mode_in = M_BANG;
            "<": mode_in = M_LT;
            ">": mode_in = M_GT;
            default: begin
               if (is_digit) begin
                  mode_in  = M_NUM;
                  accum_in = 31'(ch - "0");
               end else if (is_alpha) begin
                  mode_in    = M_IDENT;
                  name_we    = 1'b1;
                  name_waddr = '0;
                  fill_in    = 5'd1;
               end else begin
                  b_valid = 1'b1;   // b_tok already holds the error token
               end
            end
         endcase
      end
   end

   // The second token goes right behind the first, or in its place if there is no first.
   assign b_idx  = wr_ptr_ff + PTR_W'(a_valid);
   assign push_n = item_xfer ? (CNT_W'(a_valid) + CNT_W'(b_valid)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= stt_pkg::FIRST_LINE_RST;
         mode_ff       <= M_FRESH;
         fill_ff       <= '0;
         accum_ff      <= '0;
         line_ff       <= {{8{stt_pkg::FIRST_LINE_RST[7]}}, stt_pkg::FIRST_LINE_RST};
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            first_line_ff <= csr_data;
         end
         if (item_xfer) begin
            mode_ff  <= mode_in;
            fill_ff  <= fill_in;
            accum_ff <= accum_in;
            line_ff  <= line_in;
         end
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_n);
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + push_n - CNT_W'(rsp_xfer);
      end
   end

   // Payload storage: name store and result queue entries, no reset needed.
   always_ff @(posedge clock) begin
      if (item_xfer && name_we) begin
         name_ff[name_waddr] <= name_wdata;
      end
      if (item_xfer && a_valid) begin
         fifo_ff[wr_ptr_ff].tok  <= a_tok;
         fifo_ff[wr_ptr_ff].last <= !b_valid;
      end
      if (item_xfer && b_valid) begin
         fifo_ff[b_idx].tok  <= b_tok;
         fifo_ff[b_idx].last <= 1'b1;
      end
   end

endmodule

`default_nettype wire

### src/stt_checker.sv
// Port-level assertion checker for the tokenizer core, with its bind statement.
`default_nettype none
`include "assert_macros.svh"

module stt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         req_tlast,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [stt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic         rsp_tlast
);

   stt_pkg::token_type tok;

   assign tok = stt_pkg::token_type'(rsp_tdata[stt_pkg::TOKEN_W-1:0]);

   // A stalled token holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "token changed while stalled")

   // The end of a text always closes its run.
   `ASSERT_IMPLY(a_eof_last, clock, reset, rsp_tvalid && tok.kind == stt_pkg::KIND_EOF, rsp_tlast, "eof token without tlast")

   // An end-of-text transfer always leaves a token waiting.
   `ASSERT_NEXT(a_eof_queued, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid, "no token after end of text")

   // Only identifiers carry a name.
   `ASSERT_IMPLY(a_name_only_ident, clock, reset, rsp_tvalid && tok.kind != stt_pkg::KIND_IDENT, tok.length == 5'd0 && tok.chars == '0, "name on a non-identifier token")

   // Only numbers carry a value.
   `ASSERT_IMPLY(a_value_only_number, clock, reset, rsp_tvalid && tok.kind != stt_pkg::KIND_NUMBER, tok.value == 31'd0, "value on a non-number token")

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);

`default_nettype wire

### sim/token_scoreboard.sv
`timescale 1ns / 1ps
// Token predictor and in-order result checker for the source text tokenizer bench.
package token_check_pkg;
   import stt_pkg::*;

   localparam logic signed [15:0] LINE_TOP = 16'sh7FFF;

   class token_scoreboard;
      typedef enum logic [2:0] {
         LEX_FRESH, LEX_IDLE, LEX_NUMBER, LEX_NAME, LEX_EQ, LEX_BANG, LEX_LT, LEX_GT
      } lex_mode_type;

      entry_type          expected_tokens[$];
      lex_mode_type       mode;
      logic [7:0]         name_buf[NAME_SLOTS];
      int unsigned        name_fill;
      logic [30:0]        num_acc;
      logic signed [15:0] line_cnt;
      logic signed [7:0]  first_line;
      int unsigned        checked_count;
      int unsigned        error_count;

      function new();
         first_line    = FIRST_LINE_RST;
         mode          = LEX_FRESH;
         name_fill     = 0;
         num_acc       = '0;
         line_cnt      = {{8{FIRST_LINE_RST[7]}}, FIRST_LINE_RST};
         checked_count = 0;
         error_count   = 0;
         foreach (name_buf[i]) name_buf[i] = '0;
      endfunction

      function void set_first_line(logic signed [7:0] v);
         first_line = v;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit name_is(string w);
         if (name_fill != w.len()) return 0;
         for (int i = 0; i < w.len(); i++) begin
            if (name_buf[i] != w[i]) return 0;
         end
         return 1;
      endfunction

      function void emit(logic [3:0] kind, logic [3:0] sym, logic [30:0] val, int unsigned len);
         entry_type e;
         e              = '0;
         e.tok.kind     = kind;
         e.tok.symbol   = sym;
         e.tok.value    = val;
         e.tok.length   = len[4:0];
         e.tok.line_num = line_cnt;
         for (int i = 0; i < len; i++) e.tok.chars[i*8 +: 8] = name_buf[i];
         expected_tokens.push_back(e);
      endfunction

      // Emits whatever token the current mode is holding back.
      function void flush();
         case (mode)
            LEX_NUMBER: emit(KIND_NUMBER, SYM_NONE, num_acc, 0);
            LEX_NAME: begin
               if (name_is("var")) emit(KIND_VAR, SYM_NONE, '0, 0);
               else if (name_is("print")) emit(KIND_PRINT, SYM_NONE, '0, 0);
               else if (name_is("if")) emit(KIND_IF, SYM_NONE, '0, 0);
               else if (name_is("while")) emit(KIND_WHILE, SYM_NONE, '0, 0);
               else emit(KIND_IDENT, SYM_NONE, '0, name_fill);
            end
            LEX_EQ:   emit(KIND_ASSIGN, SYM_NONE, '0, 0);
            LEX_BANG: emit(KIND_ERROR, SYM_NONE, '0, 0);
            LEX_LT:   emit(KIND_RELATION, SYM_LT, '0, 0);
            LEX_GT:   emit(KIND_RELATION, SYM_GT, '0, 0);
            default: ;
         endcase
         mode      = LEX_IDLE;
         name_fill = 0;
         num_acc   = '0;
      endfunction

      function void start_char(logic [7:0] c);
         case (c)
            " ", "\t", "\r": ;
            "\n": if (line_cnt < LINE_TOP) line_cnt++;
            "+": emit(KIND_ARITH, SYM_PLUS, '0, 0);
            "-": emit(KIND_ARITH, SYM_MINUS, '0, 0);
            "*": emit(KIND_ARITH, SYM_STAR, '0, 0);
            "/": emit(KIND_ARITH, SYM_SLASH, '0, 0);
            ";": emit(KIND_SEMI, SYM_NONE, '0, 0);
            ",": emit(KIND_COMMA, SYM_NONE, '0, 0);
            ":": emit(KIND_COLON, SYM_NONE, '0, 0);
            "(": emit(KIND_PAREN, SYM_LPAREN, '0, 0);
            ")": emit(KIND_PAREN, SYM_RPAREN, '0, 0);
            "{": emit(KIND_BRACE, SYM_LBRACE, '0, 0);
            "}": emit(KIND_BRACE, SYM_RBRACE, '0, 0);
            "=": mode = LEX_EQ;
            "!": mode = LEX_BANG;
            "<": mode = LEX_LT;
            ">": mode = LEX_GT;
            default: begin
               if (is_digit(c)) begin
                  mode    = LEX_NUMBER;
                  num_acc = 31'(c - 8'd48);
               end else if (is_letter(c)) begin
                  mode        = LEX_NAME;
                  name_buf[0] = c;
                  name_fill   = 1;
               end else begin
                  emit(KIND_ERROR, SYM_NONE, '0, 0);
               end
            end
         endcase
      endfunction

      // Called once per accepted character transfer.
      function void note_char(logic [7:0] c, logic fin);
         int unsigned     n_prev;
         longint unsigned grown;
         logic [3:0]      rel;
         n_prev = expected_tokens.size();
         if (mode == LEX_FRESH) begin
            line_cnt = {{8{first_line[7]}}, first_line};
            mode     = LEX_IDLE;
         end
         if (fin) begin
            flush();
            emit(KIND_EOF, SYM_NONE, '0, 0);
            mode = LEX_FRESH;
         end else if (mode == LEX_NUMBER && is_digit(c)) begin
            grown   = 64'(num_acc) * 10 + 64'(c - 8'd48);
            num_acc = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[30:0];
         end else if (mode == LEX_NAME && (is_letter(c) || is_digit(c))
                      && name_fill < MAX_NAME) begin
            name_buf[name_fill] = c;
            name_fill++;
         end else if (mode >= LEX_EQ && c == "=") begin
            case (mode)
               LEX_EQ:   rel = SYM_EQ;
               LEX_BANG: rel = SYM_NE;
               LEX_LT:   rel = SYM_LE;
               default:  rel = SYM_GE;
            endcase
            emit(KIND_RELATION, rel, '0, 0);
            mode = LEX_IDLE;
         end else begin
            if (mode != LEX_IDLE) flush();
            start_char(c);
         end
         if (expected_tokens.size() > n_prev)
            expected_tokens[expected_tokens.size()-1].last = 1'b1;
      endfunction

      function void check_field(string what, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: token %0d, %s mismatch: expected %h, actual %h",
                     $time, checked_count, what, want, got);
            error_count++;
         end
      endfunction

      function void check_token(logic [RSP_TDATA_W-1:0] data, logic last);
         token_type got;
         entry_type want;
         got = data[TOKEN_W-1:0];
         checked_count++;
         if (expected_tokens.size() == 0) begin
            $display("%0t: token %0d not expected: expected none, actual kind %0d symbol %0d",
                     $time, checked_count, got.kind, got.symbol);
            error_count++;
            return;
         end
         want = expected_tokens.pop_front();
         check_field("token_kind", want.tok.kind, got.kind);
         check_field("symbol_code", want.tok.symbol, got.symbol);
         check_field("number_value", want.tok.value, got.value);
         check_field("name_length", want.tok.length, got.length);
         check_field("name_chars_a", want.tok.chars[63:0], got.chars[63:0]);
         check_field("name_chars_b", want.tok.chars[127:64], got.chars[127:64]);
         check_field("name_chars_c", want.tok.chars[191:128], got.chars[191:128]);
         check_field("name_chars_d", want.tok.chars[247:192], got.chars[247:192]);
         check_field("line_number", want.tok.line_num, got.line_num);
         check_field("last_of_run", want.last, last);
         check_field("tdata pad", '0, data[RSP_TDATA_W-1:TOKEN_W]);
      endfunction
   endclass

endpackage

### sim/tb.sv
`timescale 1ns / 1ps
// Top-level bench for source_text_tokenizer_core: stimulus, handshakes and the final verdict.
module tb;
   import stt_pkg::*;
   import token_check_pkg::*;

   // A receiver hold this long lets the four-entry result queue fill up and
   // forces the block to lower req_tready while characters keep coming.
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 245;
   localparam int NEWLINE_RUN    = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [7:0]             csr_data;

   // Handshake state captured at the falling edge. Nothing changes between
   // the falling edge and the next rising edge, so these values tell exactly
   // which transfers take place at that rising edge, free of any race.
   bit                     req_go;
   bit                     rsp_go;
   bit                     csr_go;
   logic [RSP_TDATA_W-1:0] rsp_data_s;
   logic                   rsp_last_s;

   bit                     req_idle_en;
   bit                     rsp_idle_en;
   bit                     long_hold_req;
   int unsigned            item_count;
   int unsigned            line_settings;
   int unsigned            quiet_cycles;

   token_scoreboard        token_sb = new();

   // Near misses sit next to the real keywords so that the keyword compare is
   // exercised on both sides of each match.
   string near_words[10] = '{"var", "print", "if", "while", "va", "vars",
                             "prin", "iff", "While", "printx"};
   string single_syms    = "+-*/;,:(){}";
   string rel_heads      = "=!<>";
   string blank_chars    = " \t\r\n";

   source_text_tokenizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(negedge clock) begin
      req_go     = req_tvalid && req_tready;
      rsp_go     = rsp_tvalid && rsp_tready;
      csr_go     = csr_valid && csr_ready;
      rsp_data_s = rsp_tdata;
      rsp_last_s = rsp_tlast;
   end

   // The watchdog only counts cycles without any transfer, so a long but
   // healthy run is never cut short; a hung handshake ends the run.
   always @(posedge clock) begin
      if (req_go || rsp_go || csr_go) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("source_text_tokenizer_core test failed");
         $finish;
      end
   end

   // Token receiver: checks every accepted token and paces rsp_tready. Short
   // random stalls come in bursts; a long hold is counted here on request.
   initial begin : rsp_side
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_go) token_sb.check_token(rsp_data_s, rsp_last_s);
         if (long_hold_req) begin
            hold          = LONG_HOLD;
            long_hold_req = 1'b0;
         end else if (hold == 0 && rsp_idle_en && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 7);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one character and returns at the edge where the transfer happens.
   // req_tvalid stays high afterwards, so back-to-back calls stream one
   // character per cycle while req_tready is high and req_idle_en is clear.
   task automatic push_char(input logic [7:0] code, input logic fin);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_go) @(posedge clock);
      token_sb.note_char(code, fin);
      item_count++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
   endtask

   // Stops offering characters and waits until every expected token is in.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (token_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The new start line only applies from the next start of text on, which
   // is also where the predictor picks it up.
   task automatic write_first_line(input logic [7:0] v);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_go) @(posedge clock);
      csr_valid <= 1'b0;
      token_sb.set_first_line(v);
      line_settings++;
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? 8'd97 : 8'd65) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'd48 + 8'($urandom_range(0, 9));
   endfunction

   // One chunk of source text. Most chunks are well formed tokens with random
   // content; noise bytes and early end-of-text marks break them up. Chunks
   // often touch each other, so one character both ends a token and starts
   // the next one.
   task automatic random_chunk();
      int pick;
      int n;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         // Long names cross the 31-character limit and get split, sometimes
         // by a digit that then starts a number.
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
         push_char(rand_letter(), 1'b0);
         for (int i = 1; i < n; i++) begin
            push_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b0);
         end
      end else if (pick < 32) begin
         push_text(near_words[$urandom_range(0, 9)]);
      end else if (pick < 48) begin
         k = $urandom_range(0, 9);
         if (k == 0) begin
            // Right at and just past the saturation point.
            push_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
         end else begin
            n = (k < 3) ? $urandom_range(9, 13) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_char(rand_digit(), 1'b0);
         end
      end else if (pick < 62) begin
         push_char(single_syms[$urandom_range(0, single_syms.len() - 1)], 1'b0);
      end else if (pick < 74) begin
         push_char(rel_heads[$urandom_range(0, 3)], 1'b0);
         if ($urandom_range(0, 1) == 0) push_char("=", 1'b0);
      end else if (pick < 86) begin
         push_char(blank_chars[$urandom_range(0, 3)], 1'b0);
      end else if (pick < 94) begin
         push_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         // The character of an end-of-text transfer is ignored; it is random
         // anyway so that nothing depends on it.
         push_char(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) push_char(" ", 1'b0);
   endtask

   task automatic run_random(input int unsigned target);
      int unsigned start;
      start = item_count;
      while (item_count - start < target) random_chunk();
   endtask

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tlast     <= 1'b0;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      req_idle_en   = 1'b1;
      rsp_idle_en   = 1'b1;
      long_hold_req = 1'b0;
      item_count    = 0;
      line_settings = 0;
      quiet_cycles  = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed text under the reset start line: the lowest and highest
      // character codes as errors, every relation pair, single < and >, a
      // lone ! and a lone =, every operator, separator and bracket, and a
      // pending number flushed by an end of text with a nonzero character.
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b0);
      push_text("x9==!=<=>=<>!;=+-*/,:(){}7");
      push_char(8'hA5, 1'b1);

      // Line counting from the highest start line the register allows, with
      // a run of newlines streamed back to back between two names.
      write_first_line(8'sd127);
      req_idle_en = 1'b0;
      push_text("a");
      repeat (NEWLINE_RUN) push_char("\n", 1'b0);
      push_text("b");
      push_char(8'h00, 1'b1);
      req_idle_en = 1'b1;

      // Lowest start line, with the long receiver hold at the front so the
      // block backs up while characters keep coming.
      write_first_line(8'h80);
      long_hold_req = 1'b1;
      run_random(RANDOM_ITEMS);

      write_first_line(8'($urandom_range(0, 255)));
      run_random(RANDOM_ITEMS);

      write_first_line(8'h00);
      run_random(RANDOM_ITEMS);

      // Last stretch at full rate on both sides.
      write_first_line(8'($urandom_range(0, 255)));
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      run_random(RANDOM_ITEMS);

      wait_drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d characters under %0d start-line settings and checked %0d tokens",
               item_count, line_settings + 1, token_sb.checked_count);
      $display("Included keywords, split names, saturated numbers and a full result backup");
      if (token_sb.error_count == 0) begin
         $display("source_text_tokenizer_core test passed");
      end else begin
         $display("source_text_tokenizer_core test failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/stt_pkg.sv
src/source_text_tokenizer_core.sv
src/stt_checker.sv
sim/token_scoreboard.sv
sim/tb.sv
